// ----- rtl/mwe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared types and constants of the Microwire EEPROM master: field widths,
// command modes, opcodes and the packed input and result beats.
// ----------------------------------------------------------------------------
package mwe_pkg;

  // Default width of the EEPROM address word (93C86 in byte organisation).
  localparam int unsigned MweAddrWidth = 11;

  // Fixed field widths of the stream beats and the register.
  localparam int unsigned AddrFieldW = 11;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned PaddrW     = 3;

  typedef enum logic [2:0] {
    MODE_READ  = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_ERASE = 3'd2,
    MODE_ERAL  = 3'd3,
    MODE_WRAL  = 3'd4,
    MODE_EWEN  = 3'd5,
    MODE_EWDS  = 3'd6
  } mode_e;

  // Two opcode bits after the start bit.
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_ERASE = 2'b11;
  localparam logic [1:0] OP_MISC  = 2'b00;

  // Top two address bits that select the extended commands.
  localparam logic [1:0] EXT_ERAL = 2'b10;
  localparam logic [1:0] EXT_WRAL = 2'b01;
  localparam logic [1:0] EXT_EWEN = 2'b11;
  localparam logic [1:0] EXT_EWDS = 2'b00;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_SEND    = 6'b000010,
    PH_DUMMY   = 6'b000100,
    PH_READ    = 6'b001000,
    PH_STANDBY = 6'b010000,
    PH_POLL    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic                  data_out_pin;
    logic [ByteW-1:0]      read_count;
    logic [ByteW-1:0]      write_data;
    logic [AddrFieldW-1:0] address;
    logic [2:0]            mode;
    logic                  start_req;
  } mwe_in_t;

  typedef struct packed {
    logic             ready_res;
    logic             read_valid;
    logic [ByteW-1:0] read_byte;
    logic             clock_pulse;
    logic             data_in_level;
    logic             chip_select;
  } mwe_res_t;

endpackage : mwe_pkg
`default_nettype wire

// ----- rtl/mwe_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_core
// Frame sequencer: one step per serial bit period. Holds the phase, the frame
// shifter and the read assembler and produces the pin levels of the period.
// ----------------------------------------------------------------------------
module mwe_core
  import mwe_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = MweAddrWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire mwe_in_t               beat_i,
  input  wire logic [AddrFieldW-1:0] max_addr_i,
  output mwe_res_t                   res_o
);

  localparam int unsigned HdrW   = 3 + ADDR_WIDTH;
  localparam int unsigned FrameW = HdrW + ByteW;
  localparam int unsigned CntW   = $clog2(FrameW + 1);

  phase_e                 phase_q, phase_d;
  logic [FrameW-1:0]      frame_q, frame_d;
  logic [CntW-1:0]        bit_cnt_q, bit_cnt_d;
  logic [ByteW-1:0]       bytes_left_q, bytes_left_d;
  logic [ByteW-1:0]       rd_shift_q, rd_shift_d;
  logic [ByteW-1:0]       last_byte_q, last_byte_d;
  mode_e                  cur_mode_q, cur_mode_d;

  logic [31:0]            adr_wide, lim_wide;
  logic [ADDR_WIDTH-1:0]  adr, lim, adr_clamped, word;
  logic [1:0]             op;
  logic                   with_data, mode_ok;
  logic [HdrW-1:0]        hdr;
  logic [ByteW-1:0]       rd_shift_nx;
  logic [CntW-1:0]        rd_cnt_nx;

  // Address and clamp, narrowed or widened to the EEPROM address word.
  assign adr_wide    = 32'(beat_i.address);
  assign lim_wide    = 32'(max_addr_i);
  assign adr         = adr_wide[ADDR_WIDTH-1:0];
  assign lim         = lim_wide[ADDR_WIDTH-1:0];
  assign adr_clamped = (adr > lim) ? lim : adr;

  always_comb begin
    op        = OP_MISC;
    word      = '0;
    with_data = 1'b0;
    mode_ok   = 1'b1;
    case (beat_i.mode)
      MODE_READ: begin
        op   = OP_READ;
        word = adr_clamped;
      end
      MODE_WRITE: begin
        op        = OP_WRITE;
        word      = adr_clamped;
        with_data = 1'b1;
      end
      MODE_ERASE: begin
        op   = OP_ERASE;
        word = adr_clamped;
      end
      MODE_ERAL: word = {EXT_ERAL, (ADDR_WIDTH - 2)'(0)};
      MODE_WRAL: begin
        word      = {EXT_WRAL, (ADDR_WIDTH - 2)'(0)};
        with_data = 1'b1;
      end
      MODE_EWEN: word = {EXT_EWEN, (ADDR_WIDTH - 2)'(0)};
      MODE_EWDS: word = {EXT_EWDS, (ADDR_WIDTH - 2)'(0)};
      default:   mode_ok = 1'b0;
    endcase
  end

  assign hdr         = {1'b1, op, word};
  assign rd_shift_nx = {rd_shift_q[ByteW-2:0], beat_i.data_out_pin};
  assign rd_cnt_nx   = (bit_cnt_q != '0) ? bit_cnt_q - CntW'(1) : bit_cnt_q;

  always_comb begin
    phase_d      = phase_q;
    frame_d      = frame_q;
    bit_cnt_d    = bit_cnt_q;
    bytes_left_d = bytes_left_q;
    rd_shift_d   = rd_shift_q;
    last_byte_d  = last_byte_q;
    cur_mode_d   = cur_mode_q;
    res_o        = '0;

    unique case (phase_q)
      PH_IDLE: begin
        if (beat_i.start_req && mode_ok) begin
          cur_mode_d   = mode_e'(beat_i.mode);
          bytes_left_d = beat_i.read_count;
          rd_shift_d   = '0;
          // The frame is left-aligned so that the next bit is always the MSB.
          frame_d      = {hdr, with_data ? beat_i.write_data : ByteW'(0)};
          bit_cnt_d    = with_data ? CntW'(FrameW) : CntW'(HdrW);
          res_o.clock_pulse = 1'b1;
          phase_d      = PH_SEND;
        end
      end
      PH_SEND: begin
        res_o.chip_select = 1'b1;
        res_o.clock_pulse = 1'b1;
        if (bit_cnt_q != '0) begin
          res_o.data_in_level = frame_q[FrameW-1];
          frame_d   = {frame_q[FrameW-2:0], 1'b0};
          bit_cnt_d = bit_cnt_q - CntW'(1);
        end
        if (bit_cnt_q <= CntW'(1)) begin
          bit_cnt_d = '0;
          phase_d   = (cur_mode_q == MODE_READ) ? PH_DUMMY : PH_STANDBY;
        end
      end
      PH_DUMMY: begin
        res_o.chip_select = 1'b1;
        res_o.clock_pulse = 1'b1;
        bit_cnt_d  = CntW'(ByteW);
        rd_shift_d = '0;
        phase_d    = (bytes_left_q == '0) ? PH_STANDBY : PH_READ;
      end
      PH_READ: begin
        res_o.chip_select = 1'b1;
        res_o.clock_pulse = 1'b1;
        rd_shift_d = rd_shift_nx;
        bit_cnt_d  = rd_cnt_nx;
        if (rd_cnt_nx == '0) begin
          res_o.read_valid = 1'b1;
          last_byte_d  = rd_shift_nx;
          rd_shift_d   = '0;
          bit_cnt_d    = CntW'(ByteW);
          if (bytes_left_q <= ByteW'(1)) begin
            bytes_left_d = '0;
            bit_cnt_d    = '0;
            phase_d      = PH_STANDBY;
          end else begin
            bytes_left_d = bytes_left_q - ByteW'(1);
          end
        end
      end
      PH_STANDBY: begin
        phase_d = (cur_mode_q == MODE_WRITE) ? PH_POLL : PH_IDLE;
      end
      PH_POLL: begin
        res_o.chip_select = 1'b1;
        if (beat_i.data_out_pin) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    res_o.read_byte = last_byte_d;
    res_o.ready_res = (phase_d == PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      frame_q      <= '0;
      bit_cnt_q    <= '0;
      bytes_left_q <= '0;
      rd_shift_q   <= '0;
      last_byte_q  <= '0;
      cur_mode_q   <= MODE_READ;
    end else if (step_i) begin
      phase_q      <= phase_d;
      frame_q      <= frame_d;
      bit_cnt_q    <= bit_cnt_d;
      bytes_left_q <= bytes_left_d;
      rd_shift_q   <= rd_shift_d;
      last_byte_q  <= last_byte_d;
      cur_mode_q   <= cur_mode_d;
    end
  end

endmodule : mwe_core
`default_nettype wire

// ----- rtl/microwire_eeprom_master_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// microwire_eeprom_master_unit
// Microwire master for a 93C86 EEPROM in byte mode. Each input beat is one
// serial bit period and yields one result beat with the pin levels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         one bit period: request, mode, address, data, count, pin
//  m_axis    out        one bit period: cs, data-in, clock, read byte, flags
//  APB       in/out     register 0 at byte address 0: highest usable address
//
//  One beat is accepted per cycle while the result register is empty or is
//  being emptied in the same cycle.
//  The result register is the only stage between the two sides, so a stalled
//  master side holds the slave side after a single beat.
//  Reset clears the sequencer to idle, the last read byte to zero and the
//  address ceiling to 2047.
// ----------------------------------------------------------------------------
module microwire_eeprom_master_unit
  import mwe_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = MweAddrWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // start_req[0], mode[3:1], address[14:4], write_data[22:15],
  // read_count[30:23], data_out_pin[31]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // chip_select[0], data_in_level[1], clock_pulse[2], read_byte[10:3],
  // read_valid[11], ready_res[12], zero fill[15:13]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned ResW = $bits(mwe_res_t);

  logic [AddrFieldW-1:0] max_addr_q, max_addr_d;
  logic                  out_valid_q, out_valid_d;
  mwe_res_t              res_q, res_d;
  mwe_res_t              res_now;
  logic                  step;
  logic                  reg_sel;
  mwe_in_t               beat;

  assign beat    = mwe_in_t'(s_axis_tdata_i);
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step    = s_axis_tvalid_i && s_axis_tready_o;

  mwe_core #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .beat_i    (beat),
    .max_addr_i(max_addr_q),
    .res_o     (res_now)
  );

  // Register file: one register, selected by the word address.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrW-1] == 1'b0);
  assign prdata  = reg_sel ? 32'(max_addr_q) : 32'd0;

  always_comb begin
    max_addr_d = max_addr_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      max_addr_d = pwdata[AddrFieldW-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (step) begin
      out_valid_d = 1'b1;
      res_d       = res_now;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_addr_q  <= {AddrFieldW{1'b1}};
      out_valid_q <= 1'b0;
    end else begin
      max_addr_q  <= max_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - ResW)'(0), res_q};

endmodule : microwire_eeprom_master_unit
`default_nettype wire
